/* hw/rtl/i2cbe_pkg.sv */
// Shared types and codes for the I2C master byte engine.
package i2cbe_pkg;

  // Stream widths; the tdata widths are padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_TUSER_W = 3;

  // Bus symbol codes
  typedef enum logic [2:0] {
    SYM_START   = 3'd0,
    SYM_SENT    = 3'd1,
    SYM_ACKSLOT = 3'd2,
    SYM_READ    = 3'd3,
    SYM_MACK    = 3'd4,
    SYM_MNACK   = 3'd5,
    SYM_STOP    = 3'd6,
    SYM_SKIP    = 3'd7
  } symbol_t;

  // Beat status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ACK  = 2'd1,
    STAT_SKIPPED = 2'd2
  } status_t;

  // Work kind of one queued item
  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Emission phase of the back end
  typedef enum logic [2:0] {
    PH_SKIP  = 3'd0,
    PH_START = 3'd1,
    PH_BIT   = 3'd2,
    PH_TAIL  = 3'd3,
    PH_STOP  = 3'd4
  } phase_t;

  // Classified item passed from front to back
  typedef struct packed {
    kind_t      kind;   // skip, sent byte with ack slot, or read byte
    logic       start;  // precede the byte with a start
    logic [7:0] data;   // byte to send or byte shifted in
    logic       tack;   // target level in the ack slot (write only)
    logic       stop;   // write: stop after ack; read: nack and stop
  } desc_t;

endpackage

/* hw/rtl/i2c_master_byte_engine_unit.sv */
// Path: an input beat is queued as a descriptor, loaded into the back-end sequencer,
// and its symbols leave through the output register. Throughput: one symbol per cycle
// while the output is not stalled; a run holds 1 to 11 symbols. Input beats are
// taken every cycle while the descriptor queue has room.
// Reset: synchronous active-low rst_n empties the queue, idles the sequencer and
// clears the read-mode and abort state.
module i2c_master_byte_engine_unit #(
  parameter int unsigned QUEUE_DEPTH = 4  // at least 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // byte_value[7:0], stop_flag[8], target_ack[9], target_byte[17:10], zero pad
  input  logic [i2cbe_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command[0], first_item[1]
  input  logic [i2cbe_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                              in_tlast,   // last_item
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // bit_value[0], read_byte[8:1], status[10:9], zero pad
  output logic [i2cbe_pkg::OUT_TDATA_W-1:0] out_tdata,
  // symbol[2:0]
  output logic [i2cbe_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                              out_tlast   // last_of_run
);
  import i2cbe_pkg::*;

  desc_t front_desc, head_desc;
  logic  q_full, q_valid, q_pop;

  assign in_tready = !q_full;

  i2cbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .desc      (front_desc)
  );

  i2cbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid && in_tready),
    .push_desc  (front_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  i2cbe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_desc  (head_desc),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* hw/rtl/i2cbe_front.sv */
// Front end: unpacks input beats, tracks transaction state, classifies items.
module i2cbe_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [i2cbe_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [i2cbe_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic                             in_tlast,
  output i2cbe_pkg::desc_t                 desc
);
  import i2cbe_pkg::*;

  logic       read_mode_r, read_mode_nxt;
  logic       aborted_r, aborted_nxt;
  logic       cmd, first, last, stopf, tack;
  logic [7:0] bv, tb;
  logic       accept;

  // Unpack the beat
  assign cmd    = in_tuser[0];
  assign first  = in_tuser[1];
  assign last   = in_tlast;
  assign bv     = in_tdata[7:0];
  assign stopf  = in_tdata[8];
  assign tack   = in_tdata[9];
  assign tb     = in_tdata[17:10];
  assign accept = in_tvalid && in_tready;

  // Classify the item and work out the transaction state it leaves
  always_comb begin
    read_mode_nxt = read_mode_r;
    aborted_nxt   = aborted_r;
    desc.kind     = KIND_WRITE;
    desc.start    = 1'b0;
    desc.data     = bv;
    desc.tack     = tack;
    desc.stop     = last && stopf;
    if (first) begin
      desc.start    = 1'b1;
      desc.data     = cmd ? (bv + 8'd1) : bv;
      desc.stop     = last && (cmd || stopf);
      read_mode_nxt = cmd;
      aborted_nxt   = tack;
    end else if (aborted_r) begin
      desc.kind = KIND_SKIP;
      desc.stop = 1'b0;
    end else if (read_mode_r) begin
      desc.kind = KIND_READ;
      desc.data = tb;
      desc.tack = 1'b0;
      desc.stop = last;
    end else begin
      aborted_nxt = tack;
    end
  end

  // Hold state between beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_mode_r <= 1'b0;
      aborted_r   <= 1'b0;
    end else if (accept) begin
      read_mode_r <= read_mode_nxt;
      aborted_r   <= aborted_nxt;
    end
  end

endmodule

/* hw/rtl/i2cbe_queue.sv */
// Short descriptor queue between the front and back ends.
module i2cbe_queue #(
  parameter int unsigned DEPTH = 4  // at least 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  i2cbe_pkg::desc_t push_desc,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output i2cbe_pkg::desc_t head_desc
);
  import i2cbe_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = mem[rd_ptr_r];

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/i2cbe_back.sv */
// Back end: walks each descriptor and emits one bus symbol per cycle while the output is not stalled.
module i2cbe_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  i2cbe_pkg::desc_t                  head_desc,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cbe_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [i2cbe_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                              out_tlast
);
  import i2cbe_pkg::*;

  desc_t      desc_r;
  logic       busy_r;
  phase_t     phase_r, phase_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;

  logic       advance, final_sym;
  symbol_t    sym;
  logic       bit_val;
  logic [7:0] rbyte;
  status_t    stat;

  logic       out_valid_r;
  symbol_t    out_sym_r;
  logic       out_bit_r, out_last_r;
  logic [7:0] out_rbyte_r;
  status_t    out_stat_r;

  // Step when a symbol is in hand and the output stage has room
  assign advance = busy_r && (!out_valid_r || out_tready);
  assign pop     = head_valid && (!busy_r || (advance && final_sym));

  // Current symbol and next phase
  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    sym         = SYM_SKIP;
    bit_val     = 1'b1;
    rbyte       = 8'd0;
    stat        = STAT_OK;
    final_sym   = 1'b0;
    unique case (phase_r)
      PH_SKIP: begin
        stat      = STAT_SKIPPED;
        final_sym = 1'b1;
      end
      PH_START: begin
        sym         = SYM_START;
        bit_val     = 1'b0;
        phase_nxt   = PH_BIT;
        bit_cnt_nxt = 3'd7;
      end
      PH_BIT: begin
        sym         = (desc_r.kind == KIND_READ) ? SYM_READ : SYM_SENT;
        bit_val     = desc_r.data[bit_cnt_r];
        bit_cnt_nxt = bit_cnt_r - 3'd1;
        if (bit_cnt_r == 3'd0) begin
          phase_nxt = PH_TAIL;
        end
      end
      PH_TAIL: begin
        phase_nxt = PH_STOP;
        if (desc_r.kind == KIND_READ) begin
          sym       = desc_r.stop ? SYM_MNACK : SYM_MACK;
          bit_val   = desc_r.stop;
          rbyte     = desc_r.data;
          final_sym = !desc_r.stop;
        end else begin
          sym       = SYM_ACKSLOT;
          bit_val   = desc_r.tack;
          stat      = desc_r.tack ? STAT_NO_ACK : STAT_OK;
          final_sym = !(desc_r.tack || desc_r.stop);
        end
      end
      PH_STOP: begin
        sym       = SYM_STOP;
        stat      = (desc_r.kind == KIND_WRITE && desc_r.tack) ? STAT_NO_ACK : STAT_OK;
        final_sym = 1'b1;
      end
      default: begin
        final_sym = 1'b1;
      end
    endcase
  end

  // Load descriptors and step through their phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      phase_r   <= PH_SKIP;
      bit_cnt_r <= 3'd7;
    end else if (pop) begin
      busy_r    <= 1'b1;
      bit_cnt_r <= 3'd7;
      if (head_desc.kind == KIND_SKIP) begin
        phase_r <= PH_SKIP;
      end else if (head_desc.start) begin
        phase_r <= PH_START;
      end else begin
        phase_r <= PH_BIT;
      end
    end else if (advance) begin
      busy_r    <= !final_sym;
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      desc_r <= head_desc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sym_r   <= sym;
      out_bit_r   <= bit_val;
      out_rbyte_r <= rbyte;
      out_stat_r  <= stat;
      out_last_r  <= final_sym;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sym_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_stat_r, out_rbyte_r, out_bit_r};

endmodule

/* hw/rtl/i2cbe_checker.sv */
// Port-level checks for the I2C master byte engine, bound to the top level.
module i2cbe_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [i2cbe_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [i2cbe_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                              out_tlast
);
  import i2cbe_pkg::*;

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A skipped symbol is a whole run on its own, marked skipped
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == SYM_SKIP |-> out_tlast && out_tdata[10:9] == STAT_SKIPPED)
    else $error("skipped symbol malformed");

  // A stop always closes its run
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == SYM_STOP |-> out_tlast && out_tdata[0])
    else $error("stop not closing run");

  // A start never ends a run
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == SYM_START |-> !out_tlast && !out_tdata[0])
    else $error("start symbol closes run");

endmodule

bind i2c_master_byte_engine_unit i2cbe_checker u_i2cbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* bench/testbench.sv */
// Self-checking bench for the I2C master byte engine: directed and random transactions.
module testbench;
  import i2cbe_pkg::*;

  // One expected bus symbol, as it leaves on the result stream
  typedef struct packed {
    symbol_t    sym;
    logic       bit_val;
    logic [7:0] rbyte;
    status_t    stat;
    logic       run_end;
  } bus_symbol_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  // Predictor state: kind of the open transaction and abort flag
  logic in_read_txn = 1'b0;
  logic txn_aborted = 1'b0;

  bus_symbol_t expected_symbols[$];
  int errors = 0;
  int bytes_sent = 0;
  int symbols_checked = 0;
  int missed_acks = 0;
  bit steady = 1'b0;  // suppress idling on both sides

  i2c_master_byte_engine_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  // Hard stop if the engine hangs
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 35);
  end

  function automatic void push_symbol(input symbol_t sym, input logic bv,
                                      input logic [7:0] rb, input status_t st);
    bus_symbol_t s;
    s.sym     = sym;
    s.bit_val = bv;
    s.rbyte   = rb;
    s.stat    = st;
    s.run_end = 1'b0;
    expected_symbols.push_back(s);
  endfunction

  function automatic void push_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) push_symbol(SYM_SENT, v[i], 8'd0, STAT_OK);
  endfunction

  // Target level in the ack slot; a missing ack closes with a stop and aborts
  function automatic void push_ack_slot(input logic tack, output logic nak);
    nak = tack;
    if (tack) begin
      push_symbol(SYM_ACKSLOT, 1'b1, 8'd0, STAT_NO_ACK);
      push_symbol(SYM_STOP, 1'b1, 8'd0, STAT_NO_ACK);
      txn_aborted = 1'b1;
    end else begin
      push_symbol(SYM_ACKSLOT, 1'b0, 8'd0, STAT_OK);
    end
  endfunction

  // Work out the symbol run that one accepted byte causes
  function automatic void predict_symbols(input logic cmd, input logic first,
                                          input logic [7:0] bv, input logic last,
                                          input logic stopf, input logic tack,
                                          input logic [7:0] tb);
    logic [7:0] addr;
    logic nak;
    bus_symbol_t tail;
    nak = 1'b0;
    if (first) begin
      in_read_txn = cmd;
      txn_aborted = 1'b0;
      push_symbol(SYM_START, 1'b0, 8'd0, STAT_OK);
      addr = cmd ? bv + 8'd1 : bv;
      push_byte(addr);
      push_ack_slot(tack, nak);
      if (!nak && last && (in_read_txn || stopf))
        push_symbol(SYM_STOP, 1'b1, 8'd0, STAT_OK);
    end else if (txn_aborted) begin
      push_symbol(SYM_SKIP, 1'b1, 8'd0, STAT_SKIPPED);
    end else if (in_read_txn) begin
      for (int i = 7; i >= 0; i--) push_symbol(SYM_READ, tb[i], 8'd0, STAT_OK);
      if (last) begin
        push_symbol(SYM_MNACK, 1'b1, tb, STAT_OK);
        push_symbol(SYM_STOP, 1'b1, 8'd0, STAT_OK);
      end else begin
        push_symbol(SYM_MACK, 1'b0, tb, STAT_OK);
      end
    end else begin
      push_byte(bv);
      push_ack_slot(tack, nak);
      if (!nak && last && stopf) push_symbol(SYM_STOP, 1'b1, 8'd0, STAT_OK);
    end
    // Flag the final symbol of the run
    tail = expected_symbols[expected_symbols.size() - 1];
    tail.run_end = 1'b1;
    expected_symbols[expected_symbols.size() - 1] = tail;
  endfunction

  // Check each result beat, then predict from each input beat taken at this edge
  always @(posedge clk) begin : watch_bus
    bus_symbol_t want;
    if (rst_n && out_tvalid && out_tready) begin
      symbols_checked++;
      if (out_tuser[2:0] == SYM_ACKSLOT && out_tdata[0]) missed_acks++;
      if (expected_symbols.size() == 0) begin
        errors++;
        $display("%0t: unexpected symbol %0d, nothing expected", $time, out_tuser[2:0]);
      end else begin
        want = expected_symbols.pop_front();
        if (out_tuser[2:0] !== want.sym) begin
          errors++;
          $display("%0t: symbol expected %0d got %0d", $time, want.sym, out_tuser[2:0]);
        end
        if (out_tdata[0] !== want.bit_val) begin
          errors++;
          $display("%0t: bit_value expected %0d got %0d", $time, want.bit_val, out_tdata[0]);
        end
        if (out_tdata[8:1] !== want.rbyte) begin
          errors++;
          $display("%0t: read_byte expected %02h got %02h", $time, want.rbyte,
                   out_tdata[8:1]);
        end
        if (out_tdata[10:9] !== want.stat) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.stat, out_tdata[10:9]);
        end
        if (out_tlast !== want.run_end) begin
          errors++;
          $display("%0t: last_of_run expected %0d got %0d", $time, want.run_end, out_tlast);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready)
      predict_symbols(in_tuser[0], in_tuser[1], in_tdata[7:0], in_tlast, in_tdata[8],
                      in_tdata[9], in_tdata[17:10]);
  end

  // Offer one transaction byte and hold it until it is taken
  task automatic send_item(input logic cmd, input logic first, input logic [7:0] bv,
                           input logic last, input logic stopf, input logic tack,
                           input logic [7:0] tb);
    while (!steady && $urandom_range(0, 99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, tb, tack, stopf, bv};
    in_tuser  <= {first, cmd};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold off the sender until every expected symbol has come back
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Address, register and data bytes; open ends and continuation after the end
  task automatic test_write_transactions();
    send_item(1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 8'hFF);
    send_item(1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00);
    send_item(1'b0, 1'b0, 8'hA5, 1'b1, 1'b1, 1'b0, 8'h5A);
    send_item(1'b0, 1'b1, 8'h5A, 1'b1, 1'b0, 1'b0, 8'h00);
    send_item(1'b1, 1'b0, 8'h3C, 1'b1, 1'b1, 1'b0, 8'hC3);
    send_item(1'b0, 1'b1, 8'h81, 1'b1, 1'b1, 1'b0, 8'h7E);
    wait_for_drain();
  endtask

  // Address wrap, master ack and nack, continuation, address-only read
  task automatic test_read_transactions();
    send_item(1'b1, 1'b1, 8'hFF, 1'b0, 1'b1, 1'b0, 8'hFF);
    send_item(1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, 1'b1, 8'h00);
    send_item(1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 8'hFF);
    send_item(1'b0, 1'b0, 8'h55, 1'b0, 1'b0, 1'b0, 8'h81);
    send_item(1'b1, 1'b1, 8'h7F, 1'b1, 1'b0, 1'b0, 8'h18);
    wait_for_drain();
  endtask

  // Missing acks on address and data, then skipped bytes
  task automatic test_missing_ack();
    send_item(1'b0, 1'b1, 8'hC4, 1'b0, 1'b1, 1'b1, 8'h00);
    send_item(1'b1, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF);
    send_item(1'b0, 1'b1, 8'h42, 1'b0, 1'b0, 1'b0, 8'h00);
    send_item(1'b0, 1'b0, 8'h99, 1'b1, 1'b1, 1'b1, 8'h00);
    send_item(1'b0, 1'b0, 8'h11, 1'b0, 1'b0, 1'b0, 8'h22);
    send_item(1'b1, 1'b1, 8'h30, 1'b0, 1'b0, 1'b1, 8'h00);
    send_item(1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'hAA);
    send_item(1'b1, 1'b1, 8'h31, 1'b1, 1'b0, 1'b1, 8'h00);
    wait_for_drain();
  endtask

  // Mostly well-formed transactions with random content, some loose bytes
  task automatic test_random_traffic(input int n_bytes);
    int done_bytes;
    int n_data;
    logic cmd;
    logic stopf;
    done_bytes = 0;
    while (done_bytes < n_bytes) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
        done_bytes++;
      end else begin
        cmd    = 1'($urandom_range(0, 1));
        stopf  = 1'($urandom_range(0, 1));
        n_data = $urandom_range(0, 4);
        send_item(cmd, 1'b1, 8'($urandom_range(0, 255)), n_data == 0, stopf,
                  $urandom_range(0, 99) < 8, 8'($urandom_range(0, 255)));
        for (int i = 1; i <= n_data; i++)
          send_item(1'($urandom_range(0, 1)), 1'b0, 8'($urandom_range(0, 255)),
                    i == n_data, stopf, $urandom_range(0, 99) < 8,
                    8'($urandom_range(0, 255)));
        done_bytes += n_data + 1;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_write_transactions();
    test_read_transactions();
    test_missing_ack();
    test_random_traffic(40);
    steady = 1'b1;
    test_random_traffic(20);
    steady = 1'b0;
    test_random_traffic(20);
    wait_for_drain();
    repeat (10) @(posedge clk);
    $display("Run covered %0d transaction bytes (writes, reads, aborts, loose bytes),",
             bytes_sent);
    $display("checking %0d bus symbols, %0d of them ack slots without acknowledge.",
             symbols_checked, missed_acks);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
